/* design/bitmap_find_first_set_clear_macros.svh */
// ----------------------------------------------------------------------------
// Bitmap find-first-set/clear assertion macros
// Concurrent assertion shorthands shared by the bitmap block.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIND_FIRST_SET_CLEAR_MACROS_SVH
`define BITMAP_FIND_FIRST_SET_CLEAR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BMFF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bitmap assertion failed");
`define BMFF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap assertion failed");
`else
`define BMFF_ASSERT(label, clk, rst_n, prop)
`define BMFF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/bmff_pkg.sv */
// ----------------------------------------------------------------------------
// Bitmap find-first-set/clear package
// Beat types, operation codes and fixed field widths of the bitmap block.
// ----------------------------------------------------------------------------
package bmff_pkg;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned CFG_W  = 5;
  localparam int unsigned POS_W  = 6;

  localparam logic [CFG_W-1:0] WIU_RESET = 5'd16;

  localparam logic [KIND_W-1:0] KIND_SET_BIT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR_BIT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET_ALL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR_ALL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ      = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  bit_number;
  } item_t;

  typedef struct packed {
    logic             bit_value;
    logic             first_set_found;
    logic [IDX_W-1:0] first_set_index;
    logic             first_clear_found;
    logic [IDX_W-1:0] first_clear_index;
    logic             all_clear;
    logic             all_set;
    logic             out_of_range;
  } result_t;

  typedef struct packed {
    logic             set_any;
    logic [POS_W-1:0] set_pos;
    logic             clr_any;
    logic [POS_W-1:0] clr_pos;
  } scan_t;

endpackage

/* design/bmff_word_scan.sv */
// ----------------------------------------------------------------------------
// Bitmap word scanner
// Finds the lowest set and the lowest clear bit of one bitmap word.
// ----------------------------------------------------------------------------
module bmff_word_scan #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic [WORD_BITS-1:0] word_i,
  output bmff_pkg::scan_t      scan_o
);
  import bmff_pkg::*;

  localparam int unsigned BIT_W = $clog2(WORD_BITS);
  localparam int unsigned PAD_W = 1 << BIT_W;

  function automatic logic [BIT_W-1:0] lowest_one(input logic [PAD_W-1:0] v);
    logic [PAD_W-1:0] x;
    logic [PAD_W-1:0] lowmask;
    logic [BIT_W-1:0] pos;
    x   = v;
    pos = '0;
    for (int l = BIT_W - 1; l >= 0; l--) begin
      lowmask = {PAD_W{1'b1}} >> (PAD_W - (1 << l));
      if ((x & lowmask) == '0) begin
        x      = x >> (1 << l);
        pos[l] = 1'b1;
      end
    end
    return pos;
  endfunction

  logic [PAD_W-1:0] set_vec;
  logic [PAD_W-1:0] clr_vec;

  assign set_vec = PAD_W'(word_i);
  assign clr_vec = PAD_W'(~word_i);

  assign scan_o.set_any = |word_i;
  assign scan_o.clr_any = ~&word_i;
  assign scan_o.set_pos = POS_W'(lowest_one(set_vec));
  assign scan_o.clr_pos = POS_W'(lowest_one(clr_vec));

endmodule

/* design/bitmap_find_first_set_clear.sv */
// ----------------------------------------------------------------------------
// Bitmap find-first-set/clear
// Bitmap store with single-bit updates, set-all and clear-all over the words
// in use, and lowest set and clear bit search over the words in use.
// ----------------------------------------------------------------------------
// Usage: drive item_i and raise start; the beat is taken at a rising edge
// where start is high and busy is low. busy then stays high while the block
// walks the words in use, one word per cycle, applying the operation and
// searching each word as it passes.
// The result beat appears on res_o with done_o high for exactly one cycle,
// in the cycle after the last word. busy is already low in the done_o cycle,
// so a new item can be taken at the end of that cycle; no item is taken
// while busy is high. The words are walked one at a time because the bitmap
// has a single word port and the block has one shared word scanner.
// The receiver cannot stall; a result must be taken when done_o is high.
// cfg_we_i writes words_in_use and is meant only while the block is idle.
// Reset clears every bitmap word at once, sets words_in_use to 16 and
// leaves the block idle and ready.
// ----------------------------------------------------------------------------
`include "bitmap_find_first_set_clear_macros.svh"

module bitmap_find_first_set_clear #(
  parameter int unsigned MAX_BITS  = 1024,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  bmff_pkg::item_t                item_i,
  input  logic                           cfg_we_i,
  input  logic [bmff_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                           done_o,
  output bmff_pkg::result_t              res_o
);
  import bmff_pkg::*;

  localparam int unsigned NUM_WORDS = MAX_BITS / WORD_BITS;
  localparam int unsigned AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned BIT_W = $clog2(WORD_BITS);
  localparam int unsigned BW    = $clog2(NUM_WORDS * WORD_BITS + 1);
  localparam int unsigned CW    = (BW > IDX_W) ? BW : IDX_W;
  localparam int unsigned NWW   = $clog2(NUM_WORDS + 1);
  localparam int unsigned LW    = (NWW > CFG_W) ? NWW : CFG_W;

  state_e                state_q, state_d;
  logic [CFG_W-1:0]      wiu_q;
  logic [WORD_BITS-1:0]  words_q [NUM_WORDS];
  logic [KIND_W-1:0]     kind_q;
  logic [IDX_W-1:0]      num_q;
  logic [AW-1:0]         last_q;
  logic [AW-1:0]         cnt_q;
  logic [BW-1:0]         base_q;
  logic                  hit_q;
  logic                  bitval_q;
  logic                  set_found_q;
  logic [IDX_W-1:0]      set_idx_q;
  logic                  clr_found_q;
  logic [IDX_W-1:0]      clr_idx_q;
  logic                  done_q;

  logic                  accept;
  logic                  last_word;
  logic [AW-1:0]         last_d;
  logic [LW-1:0]         wiu_ext;
  logic [CW-1:0]         num_ext;
  logic [CW-1:0]         base_ext;
  logic                  hit;
  logic [BIT_W-1:0]      bit_sel;
  logic [WORD_BITS-1:0]  rd_word;
  logic [WORD_BITS-1:0]  new_word;
  logic [WORD_BITS-1:0]  bit_mask;
  logic [CW-1:0]         set_sum;
  logic [CW-1:0]         clr_sum;
  scan_t                 scan;

  assign accept    = start && (state_q == ST_IDLE);
  assign busy      = (state_q != ST_IDLE);
  assign last_word = (cnt_q == last_q);

  assign wiu_ext = LW'(wiu_q);

  always_comb begin
    if (wiu_ext == '0) begin
      last_d = '0;
    end else if (wiu_ext > LW'(NUM_WORDS)) begin
      last_d = AW'(NUM_WORDS - 1);
    end else begin
      last_d = AW'(wiu_ext - LW'(1));
    end
  end

  assign num_ext  = CW'(num_q);
  assign base_ext = CW'(base_q);
  assign hit      = (num_ext >= base_ext) && (num_ext < base_ext + CW'(WORD_BITS));
  assign bit_sel  = BIT_W'(num_ext - base_ext);
  assign bit_mask = WORD_BITS'(1) << bit_sel;
  assign rd_word  = words_q[cnt_q];

  always_comb begin
    case (kind_q)
      KIND_SET_BIT: begin
        new_word = hit ? (rd_word | bit_mask) : rd_word;
      end
      KIND_CLEAR_BIT: begin
        new_word = hit ? (rd_word & ~bit_mask) : rd_word;
      end
      KIND_SET_ALL: begin
        new_word = {WORD_BITS{1'b1}};
      end
      KIND_CLEAR_ALL: begin
        new_word = '0;
      end
      KIND_READ: begin
        new_word = rd_word;
      end
      default: begin
        new_word = rd_word;
      end
    endcase
  end

  bmff_word_scan #(
    .WORD_BITS(WORD_BITS)
  ) u_scan (
    .word_i(new_word),
    .scan_o(scan)
  );

  assign set_sum = base_ext + CW'(scan.set_pos);
  assign clr_sum = base_ext + CW'(scan.clr_pos);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_word) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wiu_q <= WIU_RESET;
    end else if (cfg_we_i) begin
      wiu_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= '{default: '0};
    end else if (state_q == ST_SCAN) begin
      words_q[cnt_q] <= new_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 1'b0;
      cnt_q       <= '0;
      base_q      <= '0;
      hit_q       <= 1'b0;
      set_found_q <= 1'b0;
      clr_found_q <= 1'b0;
    end else begin
      done_q <= (state_q == ST_SCAN) && last_word;
      if (accept) begin
        cnt_q       <= '0;
        base_q      <= '0;
        hit_q       <= 1'b0;
        set_found_q <= 1'b0;
        clr_found_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        cnt_q  <= cnt_q + AW'(1);
        base_q <= base_q + BW'(WORD_BITS);
        if (hit) begin
          hit_q <= 1'b1;
        end
        if (!set_found_q && scan.set_any) begin
          set_found_q <= 1'b1;
        end
        if (!clr_found_q && scan.clr_any) begin
          clr_found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q    <= item_i.kind;
      num_q     <= item_i.bit_number;
      last_q    <= last_d;
      bitval_q  <= 1'b0;
      set_idx_q <= '0;
      clr_idx_q <= '0;
    end else if (state_q == ST_SCAN) begin
      if (hit) begin
        bitval_q <= new_word[bit_sel];
      end
      if (!set_found_q && scan.set_any) begin
        set_idx_q <= set_sum[IDX_W-1:0];
      end
      if (!clr_found_q && scan.clr_any) begin
        clr_idx_q <= clr_sum[IDX_W-1:0];
      end
    end
  end

  assign done_o                  = done_q;
  assign res_o.bit_value         = bitval_q;
  assign res_o.first_set_found   = set_found_q;
  assign res_o.first_set_index   = set_idx_q;
  assign res_o.first_clear_found = clr_found_q;
  assign res_o.first_clear_index = clr_idx_q;
  assign res_o.all_clear         = !set_found_q;
  assign res_o.all_set           = !clr_found_q;
  assign res_o.out_of_range      = !hit_q;

  `BMFF_ASSERT(a_done_when_idle, clk_i, rst_ni, done_o |-> !busy)
  `BMFF_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `BMFF_ASSERT_NEXT(a_last_word_done, clk_i, rst_ni, busy && last_word, done_o && !busy)
  `BMFF_ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, done_o, !done_o)

endmodule
